// ===== hdl/arpc_pkg.sv =====
// Shared types and constants for the ARP cache next-hop resolver.
// No dependencies; every other file refers to this package by scoped names.
package arpc_pkg;

    localparam int ENTRIES    = 256;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOCAL_IP   = 2'd0,
        REG_NET_MASK   = 2'd1,
        REG_GATEWAY_IP = 2'd2
    } cfg_reg_t;

    typedef enum logic [0:0] {
        REQ_LOOKUP = 1'b0,
        REQ_LEARN  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        OUT_HIT      = 3'd0,
        OUT_MISS     = 3'd1,
        OUT_UPDATED  = 3'd2,
        OUT_INSERTED = 3'd3,
        OUT_FULL     = 3'd4,
        OUT_ZERO     = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/arpc_if.sv =====
// Channel interfaces: request, result and configuration write.
// Depends on arpc_pkg for field widths.
interface arpc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [arpc_pkg::IP_W-1:0]  ip_addr;
    logic [arpc_pkg::MAC_W-1:0] mac_addr;

    modport source (output valid, output req_type, output ip_addr, output mac_addr,
                    input ready);
    modport sink   (input valid, input req_type, input ip_addr, input mac_addr,
                    output ready);
endinterface

interface arpc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [arpc_pkg::MAC_W-1:0] mac_out;
    logic [arpc_pkg::IP_W-1:0]  next_hop;
    logic [2:0]                 outcome;

    modport source (output valid, output found, output mac_out, output next_hop,
                    output outcome, input ready);
    modport sink   (input valid, input found, input mac_out, input next_hop,
                    input outcome, output ready);
endinterface

interface arpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [arpc_pkg::CFG_ADDR_W-1:0] addr;
    logic [arpc_pkg::IP_W-1:0]       data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hdl/arp_cache_next_hop_resolver.sv =====
// ARP cache with next-hop resolution: top level joining controller and datapath.
// Depends on arpc_pkg, the interfaces in arpc_if.sv, arpc_ctrl and arpc_dp.
//
// Usage:
//   cfg: register writes (0 local_ip, 1 net_mask, 2 gateway_ip), always ready;
//        write only while no request is in flight.
//   req: req_type 0 looks up the next hop of ip_addr (target on the local
//        subnet, else gateway) and reports hit and MAC or miss; req_type 1
//        learns ip_addr/mac_addr: update a match, insert, drop when full,
//        or ignore address zero.
//   rsp: exactly one result per request: found, mac_out, next_hop, outcome.
// Timing: one request at a time. The search reads one slot per cycle from
//   the address memory with a registered read, so a request scans up to
//   fill_count slots, fewer on an early hit. req is ready again once the
//   result is in the output register; a stalled rsp holds its result, and a
//   following request waits at its finish step until that result transfers.
// Reset: state, config and control registers and fill count clear; the table
//   is empty and no clearing pass is needed.
module arp_cache_next_hop_resolver (
    input logic       clk,
    input logic       rst_n,
    arpc_cfg_if.sink  cfg,
    arpc_req_if.sink  req,
    arpc_rsp_if.source rsp
);

    arpc_pkg::ctrl_cmd_t  cmd;
    arpc_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    arpc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg.valid),
        .cfg_addr     (cfg.addr),
        .cfg_data     (cfg.data),
        .req_type     (req.req_type),
        .ip_addr      (req.ip_addr),
        .mac_addr     (req.mac_addr),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_found    (rsp.found),
        .rsp_mac_out  (rsp.mac_out),
        .rsp_next_hop (rsp.next_hop),
        .rsp_outcome  (rsp.outcome)
    );

`ifndef ASSERT_OFF
    // a finish must never overwrite a result that has not transferred
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("finish issued while result register busy");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.search, cmd.finish}))
        else $error("controller commands overlap");

    a_load_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.search)
        else $error("search did not start after request transfer");

    a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.found == (rsp.outcome == 3'(arpc_pkg::OUT_HIT))))
        else $error("found flag disagrees with outcome");
`endif

endmodule

// ===== hdl/arpc_ctrl.sv =====
// Controller for the ARP cache: accept, search and finish sequencing.
// Depends on arpc_pkg for the state, command and status types.
module arpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  arpc_pkg::dp_status_t status,
    output arpc_pkg::ctrl_cmd_t  cmd
);

    arpc_pkg::state_t state_reg;
    arpc_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = arpc_pkg::ST_SEARCH;
                end
            end
            arpc_pkg::ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = arpc_pkg::ST_FINISH;
                end
            end
            arpc_pkg::ST_FINISH:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    state_next = arpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.search = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            arpc_pkg::ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            arpc_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/arpc_dp.sv =====
// Datapath for the ARP cache: config registers, address/MAC memories,
// pipelined linear search, table update and result register. Uses arpc_pkg.
module arpc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  arpc_pkg::ctrl_cmd_t             cmd,
    output arpc_pkg::dp_status_t            status,
    input  logic                            cfg_valid,
    input  logic [arpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [arpc_pkg::IP_W-1:0]       cfg_data,
    input  logic                            req_type,
    input  logic [arpc_pkg::IP_W-1:0]       ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]      mac_addr,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic                            rsp_found,
    output logic [arpc_pkg::MAC_W-1:0]      rsp_mac_out,
    output logic [arpc_pkg::IP_W-1:0]       rsp_next_hop,
    output logic [2:0]                      rsp_outcome
);

    localparam int IDX_W = arpc_pkg::IDX_W;
    localparam int CNT_W = arpc_pkg::CNT_W;
    localparam int IP_W  = arpc_pkg::IP_W;
    localparam int MAC_W = arpc_pkg::MAC_W;

    // configuration
    logic [IP_W-1:0] local_ip_reg, local_ip_next;
    logic [IP_W-1:0] net_mask_reg, net_mask_next;
    logic [IP_W-1:0] gateway_ip_reg, gateway_ip_next;

    // request
    logic             learn_reg, learn_next;
    logic [IP_W-1:0]  key_reg, key_next;
    logic [MAC_W-1:0] mac_in_reg, mac_in_next;
    logic [IP_W-1:0]  hop_reg, hop_next;

    // search
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [MAC_W-1:0] hit_mac_reg, hit_mac_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    // result
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [MAC_W-1:0] out_mac_reg, out_mac_next;
    logic [IP_W-1:0]  out_hop_reg, out_hop_next;
    arpc_pkg::outcome_t out_outcome_reg, out_outcome_next;

    // memories
    logic [IP_W-1:0]  entry_ip_mem  [arpc_pkg::ENTRIES];
    logic [MAC_W-1:0] entry_mac_mem [arpc_pkg::ENTRIES];
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [IP_W-1:0]  wr_ip;
    logic [MAC_W-1:0] wr_mac;
    logic             ip_we;
    logic             mac_we;

    logic            same_net;
    logic [IP_W-1:0] nh;
    logic            hit_now;
    logic            issue_end;
    logic            table_full;
    logic            out_free;

    assign same_net   = (ip_addr & net_mask_reg) == (local_ip_reg & net_mask_reg);
    assign nh         = same_net ? ip_addr : gateway_ip_reg;
    assign hit_now    = cmp_valid_reg && (rd_ip_reg == key_reg);
    assign issue_end  = (iss_reg == fill_reg);
    assign table_full = (fill_reg == CNT_W'(arpc_pkg::ENTRIES));
    assign out_free   = !out_valid_reg || rsp_ready;
    assign rd_idx     = iss_reg[IDX_W-1:0];

    assign status.search_done = hit_now || (issue_end && !cmp_valid_reg);
    assign status.out_free    = out_free;

    // configuration decode
    always_comb
    begin
        local_ip_next   = local_ip_reg;
        net_mask_next   = net_mask_reg;
        gateway_ip_next = gateway_ip_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                arpc_pkg::REG_LOCAL_IP:   local_ip_next   = cfg_data;
                arpc_pkg::REG_NET_MASK:   net_mask_next   = cfg_data;
                arpc_pkg::REG_GATEWAY_IP: gateway_ip_next = cfg_data;
                default:                  local_ip_next   = local_ip_reg;
            endcase
        end
    end

    // request capture and search pipeline
    always_comb
    begin
        learn_next     = learn_reg;
        key_next       = key_reg;
        mac_in_next    = mac_in_reg;
        hop_next       = hop_reg;
        iss_next       = iss_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_mac_next   = hit_mac_reg;

        if (cmd.load)
        begin
            learn_next  = (req_type == arpc_pkg::REQ_LEARN);
            key_next    = (req_type == arpc_pkg::REQ_LEARN) ? ip_addr : nh;
            mac_in_next = mac_addr;
            hop_next    = (req_type == arpc_pkg::REQ_LEARN) ? '0 : nh;
            iss_next    = '0;
            hit_next    = 1'b0;
        end
        else if (cmd.search)
        begin
            if (hit_now)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
                hit_mac_next = rd_mac_reg;
            end
            else if (!issue_end)
            begin
                // advance: read data for this slot returns next cycle
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx;
                iss_next       = iss_reg + CNT_W'(1);
            end
        end
    end

    // finish: table update and result
    always_comb
    begin
        fill_next        = fill_reg;
        ip_we            = 1'b0;
        mac_we           = 1'b0;
        wr_idx           = hit_idx_reg;
        wr_ip            = key_reg;
        wr_mac           = mac_in_reg;
        out_valid_next   = out_valid_reg;
        out_found_next   = out_found_reg;
        out_mac_next     = out_mac_reg;
        out_hop_next     = out_hop_reg;
        out_outcome_next = out_outcome_reg;

        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_hop_next   = hop_reg;
            out_found_next = 1'b0;
            out_mac_next   = '0;
            if (!learn_reg)
            begin
                if (hit_reg)
                begin
                    out_found_next   = 1'b1;
                    out_mac_next     = hit_mac_reg;
                    out_outcome_next = arpc_pkg::OUT_HIT;
                end
                else
                begin
                    out_outcome_next = arpc_pkg::OUT_MISS;
                end
            end
            else if (key_reg == '0)
            begin
                out_outcome_next = arpc_pkg::OUT_ZERO;
            end
            else if (hit_reg)
            begin
                mac_we           = 1'b1;
                out_outcome_next = arpc_pkg::OUT_UPDATED;
            end
            else if (!table_full)
            begin
                ip_we            = 1'b1;
                mac_we           = 1'b1;
                wr_idx           = fill_reg[IDX_W-1:0];
                fill_next        = fill_reg + CNT_W'(1);
                out_outcome_next = arpc_pkg::OUT_INSERTED;
            end
            else
            begin
                out_outcome_next = arpc_pkg::OUT_FULL;
            end
        end
    end

    // only slots below the fill count are ever compared, so no clearing pass
    always_ff @(posedge clk)
    begin
        if (ip_we)
        begin
            entry_ip_mem[wr_idx] <= wr_ip;
        end
        rd_ip_reg <= entry_ip_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            entry_mac_mem[wr_idx] <= wr_mac;
        end
        rd_mac_reg <= entry_mac_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg   <= '0;
            net_mask_reg   <= '0;
            gateway_ip_reg <= '0;
            iss_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            local_ip_reg   <= local_ip_next;
            net_mask_reg   <= net_mask_next;
            gateway_ip_reg <= gateway_ip_next;
            iss_reg        <= iss_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_reg        <= hit_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        learn_reg       <= learn_next;
        key_reg         <= key_next;
        mac_in_reg      <= mac_in_next;
        hop_reg         <= hop_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_mac_reg     <= hit_mac_next;
        out_found_reg   <= out_found_next;
        out_mac_reg     <= out_mac_next;
        out_hop_reg     <= out_hop_next;
        out_outcome_reg <= out_outcome_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp_found    = out_found_reg;
    assign rsp_mac_out  = out_mac_reg;
    assign rsp_next_hop = out_hop_reg;
    assign rsp_outcome  = 3'(out_outcome_reg);

endmodule

// ===== tb/sv/arp_cache_next_hop_resolver_tb.sv =====
// Self-checking testbench for arp_cache_next_hop_resolver: directed and random lookups and
// learns over several register settings, checked against a cycle-free cache predictor.
// Depends on arpc_pkg, the channel interfaces in arpc_if.sv and the resolver RTL.
module arp_cache_next_hop_resolver_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        arpc_pkg::req_t kind;
        logic [31:0]    ip;
        logic [47:0]    mac;
    } arp_req_t;

    typedef struct packed {
        logic               found;
        logic [47:0]        mac_out;
        logic [31:0]        next_hop;
        arpc_pkg::outcome_t outcome;
    } arp_result_t;

    logic clk;
    logic rst_n;

    arpc_cfg_if cfg_ch();
    arpc_req_if req_ch();
    arpc_rsp_if rsp_ch();

    arp_cache_next_hop_resolver DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted cache contents and registers
    logic [31:0] cache_ip  [arpc_pkg::ENTRIES];
    logic [47:0] cache_mac [arpc_pkg::ENTRIES];
    int          cache_fill = 0;
    logic [31:0] own_ip = '0;
    logic [31:0] subnet_mask = '0;
    logic [31:0] gw_ip = '0;

    // Stimulus side
    arp_req_t    req_backlog[$];
    arp_result_t pending_results[$];
    logic [31:0] learned_pool[$];
    logic [31:0] phase_local;
    logic [31:0] phase_mask;
    bit          idle_on;
    int          sent_total = 0;
    int          answered_total = 0;
    int          settings_applied = 0;
    int          fail_count = 0;
    int          outcome_tally[0:5];

    // Driver and monitor state
    arp_req_t    next_item;
    arp_result_t want;
    logic        req_fire;
    logic        cfg_fire;
    int          req_gap = 0;
    int          rsp_stall = 0;
    int          quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int find_entry(logic [31:0] addr);
        int i;
        int hit_at;
        hit_at = -1;
        for (i = 0; i < cache_fill && hit_at < 0; i++)
        begin
            if (cache_ip[i] == addr)
                hit_at = i;
        end
        return hit_at;
    endfunction

    function automatic arp_result_t resolve_and_learn(arpc_pkg::req_t kind, logic [31:0] ip,
                                                      logic [47:0] mac);
        arp_result_t r;
        logic [31:0] hop;
        int          slot;
        r.found    = 1'b0;
        r.mac_out  = '0;
        r.next_hop = '0;
        r.outcome  = arpc_pkg::OUT_MISS;
        if (kind == arpc_pkg::REQ_LOOKUP)
        begin
            hop = ((ip & subnet_mask) == (own_ip & subnet_mask)) ? ip : gw_ip;
            slot = find_entry(hop);
            r.next_hop = hop;
            if (hop != 0 && slot >= 0)
            begin
                r.found   = 1'b1;
                r.mac_out = cache_mac[slot];
                r.outcome = arpc_pkg::OUT_HIT;
            end
        end
        else if (ip == 0)
        begin
            r.outcome = arpc_pkg::OUT_ZERO;
        end
        else
        begin
            slot = find_entry(ip);
            if (slot >= 0)
            begin
                cache_mac[slot] = mac;
                r.outcome = arpc_pkg::OUT_UPDATED;
            end
            else if (cache_fill < arpc_pkg::ENTRIES)
            begin
                cache_ip[cache_fill]  = ip;
                cache_mac[cache_fill] = mac;
                cache_fill++;
                r.outcome = arpc_pkg::OUT_INSERTED;
            end
            else
            begin
                r.outcome = arpc_pkg::OUT_FULL;
            end
        end
        return r;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic bit in_pool(logic [31:0] addr);
        foreach (learned_pool[i])
        begin
            if (learned_pool[i] == addr)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] pool_pick();
        return learned_pool[$urandom_range(0, learned_pool.size() - 1)];
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [47:0] v;
        int r;
        r = $urandom_range(0, 19);
        v[31:0]  = $urandom();
        v[47:32] = 16'($urandom_range(0, 65535));
        if (r == 0)
            v = '1;
        else if (r == 1)
            v = '0;
        return v;
    endfunction

    task automatic add_request(arpc_pkg::req_t kind, logic [31:0] ip, logic [47:0] mac);
        arp_req_t item;
        item.kind = kind;
        item.ip   = ip;
        item.mac  = mac;
        req_backlog.push_back(item);
        sent_total++;
        if (kind == arpc_pkg::REQ_LEARN && ip != 0 && !in_pool(ip))
            learned_pool.push_back(ip);
    endtask

    task automatic gen_request(int fresh_pct);
        logic [31:0] ip;
        int r;
        r = $urandom_range(0, 99);
        if (r < fresh_pct || (r < fresh_pct + 15 && learned_pool.size() == 0))
        begin
            if ($urandom_range(0, 1) == 1)
                ip = (phase_local & phase_mask) | ($urandom() & ~phase_mask);
            else
                ip = $urandom();
            while (ip == 0 || in_pool(ip))
                ip = $urandom();
            add_request(arpc_pkg::REQ_LEARN, ip, rand_mac());
        end
        else if (r < fresh_pct + 15)
            add_request(arpc_pkg::REQ_LEARN, pool_pick(), rand_mac());
        else if (r < fresh_pct + 17)
            add_request(arpc_pkg::REQ_LEARN, '0, rand_mac());
        else if (r < fresh_pct + 52)
            add_request(arpc_pkg::REQ_LOOKUP, pool_pick(), rand_mac());
        else if (r < fresh_pct + 62)
            add_request(arpc_pkg::REQ_LOOKUP,
                        (~phase_local & phase_mask) | ($urandom() & ~phase_mask),
                        rand_mac());
        else if (r < fresh_pct + 64)
            add_request(arpc_pkg::REQ_LOOKUP, '0, rand_mac());
        else
            add_request(arpc_pkg::REQ_LOOKUP, $urandom(), rand_mac());
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (answered_total != sent_total);
    endtask

    // Caller stands at a falling edge; returns at the falling edge after the transfer
    task automatic write_reg(arpc_pkg::cfg_reg_t idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        do
            @(negedge clk);
        while (!cfg_fire);
    endtask

    task automatic set_config(logic [31:0] l, logic [31:0] m, logic [31:0] g);
        @(negedge clk);
        phase_local = l;
        phase_mask  = m;
        write_reg(arpc_pkg::REG_LOCAL_IP, l);
        write_reg(arpc_pkg::REG_NET_MASK, m);
        write_reg(arpc_pkg::REG_GATEWAY_IP, g);
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_random(int count, int fresh_pct, bit with_idle, bit fill_table);
        int n;
        idle_on = with_idle;
        n = 0;
        while (n < count || (fill_table && learned_pool.size() < arpc_pkg::ENTRIES + 24))
        begin
            gen_request(fresh_pct);
            n++;
        end
        wait_drained();
    endtask

    task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected,
                     actual);
        end
    endtask

    // Driver: present requests and stall results at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_fire)
            begin
                if (req_gap > 0)
                begin
                    req_ch.valid <= 1'b0;
                    req_gap = req_gap - 1;
                end
                else if (req_backlog.size() != 0)
                begin
                    next_item = req_backlog.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= next_item.kind;
                    req_ch.ip_addr  <= next_item.ip;
                    req_ch.mac_addr <= next_item.mac;
                    req_gap = (idle_on && $urandom_range(0, 99) < 40) ? pick_len() : 0;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall = rsp_stall - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 15)
                    rsp_stall = pick_len();
            end
        end
    end

    // Monitor: check results, then predict for newly accepted requests
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_fire <= 1'b0;
            cfg_fire <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            cfg_fire <= cfg_ch.valid && cfg_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                answered_total++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request pending, outcome %0d", $time,
                             rsp_ch.outcome);
                end
                else
                begin
                    want = pending_results.pop_front();
                    outcome_tally[want.outcome]++;
                    check_field("found", want.found, rsp_ch.found);
                    check_field("mac_out", want.mac_out, rsp_ch.mac_out);
                    check_field("next_hop", want.next_hop, rsp_ch.next_hop);
                    check_field("outcome", want.outcome, rsp_ch.outcome);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (arpc_pkg::cfg_reg_t'(cfg_ch.addr))
                    arpc_pkg::REG_LOCAL_IP:   own_ip = cfg_ch.data;
                    arpc_pkg::REG_NET_MASK:   subnet_mask = cfg_ch.data;
                    arpc_pkg::REG_GATEWAY_IP: gw_ip = cfg_ch.data;
                    default:                  ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(
                    resolve_and_learn(arpc_pkg::req_t'(req_ch.req_type),
                                      req_ch.ip_addr, req_ch.mac_addr));
            if ((rsp_ch.valid && rsp_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (req_ch.valid && req_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = arpc_pkg::REG_LOCAL_IP;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = arpc_pkg::REQ_LOOKUP;
        req_ch.ip_addr = '0;
        req_ch.mac_addr = '0;
        rsp_ch.ready = 1'b0;
        idle_on = 1'b1;
        phase_local = '0;
        phase_mask = '0;
        foreach (outcome_tally[i])
            outcome_tally[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at reset: zero mask puts every target on the local subnet
        add_request(arpc_pkg::REQ_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LEARN,  32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LEARN,  32'h0000_0001, 48'h0000_0000_0000);
        add_request(arpc_pkg::REQ_LEARN,  32'hFFFF_FFFF, 48'h1234_5678_9ABC);
        add_request(arpc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h0000_0002, 48'h0000_0000_0000);
        wait_drained();

        set_config(32'hC0A8_0001, 32'hFFFF_FF00, 32'hC0A8_00FE);
        add_request(arpc_pkg::REQ_LEARN,  32'hC0A8_00FE, 48'h0000_5E00_0101);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h0808_0808, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LOOKUP, 32'hC0A8_0005, 48'h0000_0000_0000);
        add_request(arpc_pkg::REQ_LEARN,  32'hC0A8_0005, 48'hA5A5_5A5A_C3C3);
        add_request(arpc_pkg::REQ_LOOKUP, 32'hC0A8_0005, 48'h0000_0000_0000);
        wait_drained();

        // Zero gateway: every off-subnet lookup resolves to address zero
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h1234_5678, 48'h0000_0000_0000);
        add_request(arpc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_request(arpc_pkg::REQ_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000);
        wait_drained();

        set_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(arpc_pkg::REQ_LOOKUP, 32'hC0A8_00FE, 48'h0000_0000_0000);
        wait_drained();

        // Random phases; the fourth one fills the table and the rest run it full
        set_config($urandom(), 32'hFFFF_FF00, pool_pick());
        run_random(300, 20, 1'b1, 1'b0);
        set_config($urandom(), 32'h0000_0000, $urandom());
        run_random(300, 25, 1'b0, 1'b0);
        set_config($urandom(), 32'hFFFF_FFFF, pool_pick());
        run_random(250, 30, 1'b1, 1'b0);
        len = $urandom_range(8, 30);
        set_config($urandom(), 32'hFFFF_FFFF << (32 - len), pool_pick());
        run_random(200, 40, 1'b1, 1'b1);
        set_config(32'hFFFF_FFFF, 32'hFFFF_0000, pool_pick());
        run_random(250, 25, 1'b1, 1'b0);
        set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(100, 20, 1'b1, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Checked %0d requests over %0d register settings, table holds %0d of %0d.",
                 answered_total, settings_applied, cache_fill, arpc_pkg::ENTRIES);
        $display("Outcomes: %0d hit, %0d miss, %0d updated, %0d inserted, %0d dropped, %0d zero.",
                 outcome_tally[arpc_pkg::OUT_HIT], outcome_tally[arpc_pkg::OUT_MISS],
                 outcome_tally[arpc_pkg::OUT_UPDATED], outcome_tally[arpc_pkg::OUT_INSERTED],
                 outcome_tally[arpc_pkg::OUT_FULL], outcome_tally[arpc_pkg::OUT_ZERO]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/arpc_pkg.sv
hdl/arpc_if.sv
hdl/arpc_ctrl.sv
hdl/arpc_dp.sv
hdl/arp_cache_next_hop_resolver.sv
tb/sv/arp_cache_next_hop_resolver_tb.sv
